>>> rtl/itp_pkg.sv
// Shared types, constants and helper functions for the infix-to-postfix converter.
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    typedef enum logic [1:0] {
        ERR_NONE            = 2'd0,
        ERR_OVERFLOW        = 2'd1,
        ERR_UNMATCHED_CLOSE = 2'd2,
        ERR_UNCLOSED_OPEN   = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        CLS_OPERAND,
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OP
    } t_cls;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_SETTLE,
        ST_FLUSH,
        ST_END
    } t_state;

    typedef struct packed {
        logic [7:0] in_char;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       has_char;
        logic       run_last;
        logic       expr_done;
        logic [1:0] error_code;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic       in_ready;
        logic       push;
        logic       pop;
        logic       emit;
        logic [7:0] e_char;
        logic       e_has;
        t_err       e_err;
        logic       finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       in_valid;
        logic       go;
        logic       empty;
        logic       full;
        logic [7:0] top;
        logic [7:0] chr;
        logic       last;
    } t_sts;

    function automatic logic [1:0] prec_of(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            CH_CARET:       p = 2'd3;
            CH_MUL, CH_DIV: p = 2'd2;
            CH_ADD, CH_SUB: p = 2'd1;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic t_cls class_of(input logic [7:0] c);
        t_cls k;
        if (c == CH_OPEN) begin
            k = CLS_OPEN;
        end else if (c == CH_CLOSE) begin
            k = CLS_CLOSE;
        end else if (prec_of(c) != 2'd0) begin
            k = CLS_OP;
        end else begin
            k = CLS_OPERAND;
        end
        return k;
    endfunction

endpackage

>>> rtl/itp_stream_if.sv
// Valid/ready stream interface carrying one item per handshake.
interface itp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/itp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/itp_datapath.sv
// Datapath: input latch, operator stack, pending result and output register.
module itp_datapath #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    itp_stream_if.sink    i_in_item,
    itp_stream_if.source  o_out_item,
    input  itp_pkg::t_cmd i_cmd,
    output itp_pkg::t_sts o_sts
);
    import itp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] w_top_idx;
    logic [7:0]    r_chr;
    logic          r_last;
    logic [7:0]    w_rdata;
    logic          w_accept;
    logic          w_go;

    t_out_item     r_hold, n_hold;
    logic          r_hold_v, n_hold_v;
    t_out_item     r_out, n_out;
    logic          r_out_v, n_out_v;
    t_out_item     w_new;

    assign w_accept = i_in_item.valid && i_cmd.in_ready;
    assign w_go     = !r_out_v || o_out_item.ready;

    assign n_count   = r_count + CW'(i_cmd.push) - CW'(i_cmd.pop);
    assign w_top_idx = n_count - CW'(1);

    itp_ram #(
        .WIDTH (8),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_chr),
        .i_raddr (w_top_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_new            = '0;
        w_new.out_char   = i_cmd.e_char;
        w_new.has_char   = i_cmd.e_has;
        w_new.error_code = i_cmd.e_err;

        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        n_out    = r_out;
        n_out_v  = r_out_v && !o_out_item.ready;

        if (i_cmd.emit) begin
            if (r_hold_v) begin
                n_out   = r_hold;
                n_out_v = 1'b1;
            end
            n_hold   = w_new;
            n_hold_v = 1'b1;
        end else if (i_cmd.finish) begin
            if (r_hold_v) begin
                n_out           = r_hold;
                n_out.run_last  = 1'b1;
                n_out.expr_done = r_last;
                n_out_v         = 1'b1;
                n_hold_v        = 1'b0;
            end else if (r_last) begin
                n_out           = '0;
                n_out.run_last  = 1'b1;
                n_out.expr_done = 1'b1;
                n_out_v         = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_chr  <= i_in_item.payload.in_char;
            r_last <= i_in_item.payload.is_last;
        end
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    assign i_in_item.ready    = i_cmd.in_ready;
    assign o_out_item.valid   = r_out_v;
    assign o_out_item.payload = r_out;

    assign o_sts.in_valid = i_in_item.valid;
    assign o_sts.go       = w_go;
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(STACK_DEPTH));
    assign o_sts.top      = w_rdata;
    assign o_sts.chr      = r_chr;
    assign o_sts.last     = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_final_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_last) |=> (r_out_v && r_out.expr_done && r_out.run_last))
        else $error("final item produced no closing result");
endmodule

>>> rtl/itp_ctrl.sv
// Controller FSM: sequences pops, pushes, emits and the final flush per item.
module itp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  itp_pkg::t_sts i_sts,
    output itp_pkg::t_cmd o_cmd
);
    import itp_pkg::*;

    t_state     r_state, n_state;
    t_cmd       w_cmd;
    logic [1:0] w_pc, w_pt;
    logic       w_pops;

    assign w_pc   = prec_of(i_sts.chr);
    assign w_pt   = prec_of(i_sts.top);
    assign w_pops = !i_sts.empty && (w_pt != 2'd0)
                  && ((w_pt > w_pc) || ((w_pt == w_pc) && (i_sts.chr != CH_CARET)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                w_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if (i_sts.go) begin
                    case (class_of(i_sts.chr))
                        CLS_OPEN: begin
                            if (i_sts.full) begin
                                w_cmd.emit  = 1'b1;
                                w_cmd.e_err = ERR_OVERFLOW;
                            end else begin
                                w_cmd.push = 1'b1;
                            end
                            n_state = i_sts.last ? ST_SETTLE : ST_END;
                        end
                        CLS_CLOSE: begin
                            if (i_sts.empty) begin
                                w_cmd.emit  = 1'b1;
                                w_cmd.e_err = ERR_UNMATCHED_CLOSE;
                                n_state     = i_sts.last ? ST_FLUSH : ST_END;
                            end else if (i_sts.top == CH_OPEN) begin
                                w_cmd.pop = 1'b1;
                                n_state   = i_sts.last ? ST_FLUSH : ST_END;
                            end else begin
                                w_cmd.pop    = 1'b1;
                                w_cmd.emit   = 1'b1;
                                w_cmd.e_char = i_sts.top;
                                w_cmd.e_has  = 1'b1;
                            end
                        end
                        CLS_OP: begin
                            if (w_pops) begin
                                w_cmd.pop    = 1'b1;
                                w_cmd.emit   = 1'b1;
                                w_cmd.e_char = i_sts.top;
                                w_cmd.e_has  = 1'b1;
                            end else begin
                                if (i_sts.full) begin
                                    w_cmd.emit  = 1'b1;
                                    w_cmd.e_err = ERR_OVERFLOW;
                                end else begin
                                    w_cmd.push = 1'b1;
                                end
                                n_state = i_sts.last ? ST_SETTLE : ST_END;
                            end
                        end
                        default: begin
                            w_cmd.emit   = 1'b1;
                            w_cmd.e_char = i_sts.chr;
                            w_cmd.e_has  = 1'b1;
                            n_state      = i_sts.last ? ST_FLUSH : ST_END;
                        end
                    endcase
                end
            end
            ST_SETTLE: begin
                n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                if (i_sts.empty) begin
                    n_state = ST_END;
                end else if (i_sts.go) begin
                    w_cmd.pop  = 1'b1;
                    w_cmd.emit = 1'b1;
                    if (i_sts.top == CH_OPEN) begin
                        w_cmd.e_err = ERR_UNCLOSED_OPEN;
                    end else begin
                        w_cmd.e_char = i_sts.top;
                        w_cmd.e_has  = 1'b1;
                    end
                end
            end
            ST_END: begin
                if (i_sts.go) begin
                    w_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    a_no_push_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.push && w_cmd.pop))
        else $error("push and pop in one cycle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.pop |-> !i_sts.empty)
        else $error("pop from empty stack");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.push |-> !i_sts.full)
        else $error("push onto full stack");

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit || w_cmd.finish) |-> i_sts.go)
        else $error("result issued while output stalled");
endmodule

>>> rtl/infix_to_postfix_converter_top.sv
// Top level of the shunting-yard infix-to-postfix converter.
//
//   port        dir  item fields
//   i_in_item   in   in_char[7:0], is_last
//   o_out_item  out  out_char[7:0], has_char, run_last, expr_done, error_code[1:0]
//
// An item is checked in ST_CHK, once more per operator popped, and closed in ST_END;
// a final item flushes the stack in ST_FLUSH (via ST_SETTLE after an opening bracket
// or operator). The single RAM read port paces pops: one per cycle unless output stalls.
// Reset (i_rst_n low, synchronous) empties the stack and drops pending results.
// A stalled output holds the controller; the next item is taken once all
// results but the last registered one have left.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    itp_stream_if.sink   i_in_item,
    itp_stream_if.source o_out_item
);
    import itp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    itp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    itp_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .o_out_item (o_out_item),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts)
    );
endmodule
